@@ sv/sbc_pkg.sv @@
// Package for the stack bytecode core: word types, codes and depth defaults.
`default_nettype none
package sbc_pkg;

    localparam int unsigned CodeDepthDefault  = 256;
    localparam int unsigned StackDepthDefault = 1024;

    // Item operation codes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_EXEC    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Instruction codes
    localparam logic [31:0] I_HALT  = 32'd0;
    localparam logic [31:0] I_PUSH  = 32'd1;
    localparam logic [31:0] I_PRINT = 32'd2;
    localparam logic [31:0] I_ADD   = 32'd3;
    localparam logic [31:0] I_SUB   = 32'd4;
    localparam logic [31:0] I_MUL   = 32'd5;
    localparam logic [31:0] I_LT    = 32'd6;
    localparam logic [31:0] I_EQ    = 32'd7;
    localparam logic [31:0] I_BT    = 32'd8;
    localparam logic [31:0] I_BF    = 32'd9;
    localparam logic [31:0] I_LOAD  = 32'd10;
    localparam logic [31:0] I_CALL  = 32'd11;
    localparam logic [31:0] I_RET   = 32'd12;

    // Fault codes
    localparam logic [2:0] F_OK    = 3'd0;
    localparam logic [2:0] F_OVER  = 3'd1;
    localparam logic [2:0] F_UNDER = 3'd2;
    localparam logic [2:0] F_BADOP = 3'd3;
    localparam logic [2:0] F_ADDR  = 3'd4;

    // ALU operation codes
    localparam logic [2:0] A_ADD = 3'd0;
    localparam logic [2:0] A_SUB = 3'd1;
    localparam logic [2:0] A_MUL = 3'd2;
    localparam logic [2:0] A_LT  = 3'd3;
    localparam logic [2:0] A_EQ  = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  code_address;
        logic signed [31:0] code_word;
    } t_in_word;

    typedef struct packed {
        logic        printed;
        logic signed [31:0] print_value;
        logic        halted;
        logic [2:0]  fault;
        logic [7:0]  next_pc;
    } t_out_word;

endpackage
`default_nettype wire

@@ sv/sbc_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module sbc_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output      logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ sv/sbc_alu.sv @@
// Shared arithmetic and compare unit for the stack core.
`default_nettype none
module sbc_alu (
    input  wire logic [2:0]  i_op,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output      logic [31:0] o_r
);
    import sbc_pkg::*;
    logic [31:0] w_prod;

    // Keep only the low word of the product
    assign w_prod = i_a * i_b;

    // Select result of one operation
    always_comb begin
        unique case (i_op)
            A_ADD:   o_r = i_a + i_b;
            A_SUB:   o_r = i_a - i_b;
            A_MUL:   o_r = w_prod;
            A_LT:    o_r = {31'd0, $signed(i_a) < $signed(i_b)};
            A_EQ:    o_r = {31'd0, i_a == i_b};
            default: o_r = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ sv/stack_bytecode_cpu_unit.sv @@
// Top level of the stack bytecode core: sequencer, code and stack memories.
// One input word is taken at a time and the input stalls until its result word has
// been loaded into the output register. A code write, a restart or an execute while
// halted goes straight from the accepting state to the done and output states; an
// execute first fetches the instruction and operands, then uses the stack as needed.
// The steps are set by the single-port code and stack RAMs with registered read,
// which the sequencer walks one word per cycle. The result shows in the same cycle
// as the input is ready again; a stalled result holds the sequencer until taken.
`default_nettype none
module stack_bytecode_cpu_unit
    import sbc_pkg::*;
#(
    parameter int unsigned CODE_DEPTH  = CodeDepthDefault,
    parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output      logic      o_stall,
    input  wire t_in_word  i_data,
    output      logic      o_valid,
    input  wire logic      i_stall,
    output      t_out_word o_data
);
    localparam int unsigned CW = $clog2(CODE_DEPTH);
    localparam int unsigned SW = $clog2(STACK_DEPTH);
    localparam int unsigned CNT_W = SW + 1;
    localparam logic [CNT_W-1:0] SDEPTH = CNT_W'(STACK_DEPTH);

    localparam logic [4:0] S_IDLE = 5'd0,  S_FETCH = 5'd1,  S_FWAIT = 5'd2,
                           S_DEC  = 5'd3,  S_OP1   = 5'd4,  S_OP1W  = 5'd5,
                           S_OP2  = 5'd6,  S_OP2W  = 5'd7,  S_RDB   = 5'd8,
                           S_RDBW = 5'd9,  S_RDA   = 5'd10, S_RDAW  = 5'd11,
                           S_EXEC = 5'd12, S_PUSH2 = 5'd13, S_PUSH3 = 5'd14,
                           S_RF0  = 5'd15, S_RF0W  = 5'd16, S_RF1   = 5'd17,
                           S_RF1W = 5'd18, S_RF2   = 5'd19, S_RF2W  = 5'd20,
                           S_RCHK = 5'd21, S_DONE  = 5'd22, S_OUT   = 5'd23;

    logic [4:0]       r_st, n_st;
    logic [CW-1:0]    r_ip, n_ip;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_fp, n_fp;
    logic             r_halt, n_halt;
    t_in_word         r_in, n_in;
    logic [31:0]      r_w, n_w, r_o1, n_o1, r_o2, n_o2, r_a, n_a, r_b, n_b;
    logic [31:0]      r_s0, n_s0, r_s1, n_s1;
    logic [2:0]       r_flt, n_flt;
    logic             r_pr, n_pr;
    logic             r_ov, n_ov;
    t_out_word        r_out, n_out;

    // Code RAM port
    logic          c_we;
    logic [CW-1:0] c_addr;
    logic [31:0]   c_wd, c_rd;
    // Stack RAM port
    logic          s_we;
    logic [SW-1:0] s_addr;
    logic [31:0]   s_wd, s_rd;
    // Shared ALU
    logic [2:0]    alu_op;
    logic [31:0]   alu_a, alu_b, alu_r;

    sbc_ram #(.Width(32), .Depth(CODE_DEPTH)) u_code (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr), .i_wdata(c_wd), .o_rdata(c_rd));
    sbc_ram #(.Width(32), .Depth(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdata(s_wd), .o_rdata(s_rd));
    sbc_alu u_alu (.i_op(alu_op), .i_a(alu_a), .i_b(alu_b), .o_r(alu_r));

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // Helpers
    logic [CW-1:0]    ip1, ip2, ip3;
    logic [33:0]      idx;
    logic [CW-1:0]    ret_pc;
    assign ip1 = r_ip + CW'(1);
    assign ip2 = r_ip + CW'(2);
    assign ip3 = r_ip + CW'(3);

    function automatic logic in_code(input logic [31:0] t);
        in_code = ({1'b0, t} < 33'(CODE_DEPTH));
    endfunction

    always_comb begin
        n_st = r_st; n_ip = r_ip; n_cnt = r_cnt; n_fp = r_fp; n_halt = r_halt;
        n_in = r_in; n_w = r_w; n_o1 = r_o1; n_o2 = r_o2; n_a = r_a; n_b = r_b;
        n_s0 = r_s0; n_s1 = r_s1; n_flt = r_flt; n_pr = r_pr; n_ov = r_ov;
        n_out = r_out;
        c_we = 1'b0; c_addr = r_ip; c_wd = r_in.code_word;
        s_we = 1'b0; s_addr = SW'(r_cnt - CNT_W'(1)); s_wd = r_a;
        alu_op = A_ADD; alu_a = r_a; alu_b = r_b;
        ret_pc = '0;
        idx = 34'(r_fp) + {{2{r_o1[31]}}, r_o1};

        // Release result word
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_st)
            S_IDLE: begin
                if (i_valid) begin
                    n_in = i_data; n_flt = F_OK; n_pr = 1'b0; n_a = '0;
                    unique case (i_data.opcode)
                        OP_WRITE:   n_st = S_DONE;
                        OP_RESTART: begin
                            n_ip = '0; n_cnt = '0; n_fp = '0; n_halt = 1'b0;
                            n_st = S_DONE;
                        end
                        OP_EXEC:    n_st = r_halt ? S_DONE : S_FETCH;
                        default:    n_st = S_DONE;
                    endcase
                end
            end
            S_FETCH: begin c_addr = r_ip; n_st = S_FWAIT; end
            S_FWAIT: begin n_w = c_rd; c_addr = ip1; n_st = S_DEC; end
            S_DEC: begin
                n_o1 = c_rd; c_addr = ip2; n_st = S_OP2;
            end
            S_OP2: begin
                n_o2 = c_rd;
                if (r_w > I_RET) begin
                    n_flt = F_BADOP; n_st = S_DONE;
                end else begin
                    unique case (r_w) inside
                        I_HALT: begin n_halt = 1'b1; n_ip = ip1; n_st = S_DONE; end
                        I_PUSH: begin
                            if (r_cnt >= SDEPTH) begin n_flt = F_OVER; n_st = S_DONE; end
                            else n_st = S_EXEC;
                        end
                        I_LOAD: begin
                            if (idx[33] || idx >= 34'(r_cnt)) begin
                                n_flt = F_UNDER; n_st = S_DONE;
                            end else if (r_cnt >= SDEPTH) begin
                                n_flt = F_OVER; n_st = S_DONE;
                            end else n_st = S_RDB;
                        end
                        I_CALL: begin
                            if (r_cnt > SDEPTH - CNT_W'(3)) begin
                                n_flt = F_OVER; n_st = S_DONE;
                            end else if (!in_code(c_rd)) begin
                                n_flt = F_ADDR; n_st = S_DONE;
                            end else n_st = S_EXEC;
                        end
                        I_RET: begin
                            if (r_cnt < CNT_W'(1) || r_fp < CNT_W'(2) ||
                                (r_fp + CNT_W'(2)) > r_cnt) begin
                                n_flt = F_UNDER; n_st = S_DONE;
                            end else n_st = S_RF0;
                        end
                        I_PRINT, I_BT, I_BF: begin
                            if (r_cnt < CNT_W'(1)) begin n_flt = F_UNDER; n_st = S_DONE; end
                            else n_st = S_RDB;
                        end
                        default: begin
                            if (r_cnt < CNT_W'(2)) begin n_flt = F_UNDER; n_st = S_DONE; end
                            else n_st = S_RDB;
                        end
                    endcase
                end
            end
            // Read top of stack, or the frame entry for a load
            S_RDB: begin
                s_addr = (r_w == I_LOAD) ? SW'(idx) : SW'(r_cnt - CNT_W'(1));
                n_st = S_RDBW;
            end
            S_RDBW: begin
                n_b = s_rd;
                s_addr = SW'(r_cnt - CNT_W'(2));
                if (r_w >= I_ADD && r_w <= I_EQ) n_st = S_RDAW;
                else n_st = S_EXEC;
            end
            S_RDAW: begin n_a = s_rd; n_st = S_EXEC; end
            S_EXEC: begin
                unique case (r_w) inside
                    I_PUSH: begin
                        s_we = 1'b1; s_addr = SW'(r_cnt); s_wd = r_o1;
                        n_cnt = r_cnt + CNT_W'(1); n_ip = ip2; n_st = S_DONE;
                    end
                    I_LOAD: begin
                        s_we = 1'b1; s_addr = SW'(r_cnt); s_wd = r_b;
                        n_cnt = r_cnt + CNT_W'(1); n_ip = ip2; n_st = S_DONE;
                    end
                    I_PRINT: begin
                        n_pr = 1'b1; n_a = r_b;
                        n_cnt = r_cnt - CNT_W'(1); n_ip = ip1; n_st = S_DONE;
                    end
                    I_BT, I_BF: begin
                        if ((r_w == I_BT) == (r_b != '0)) begin
                            if (!in_code(r_o1)) n_flt = F_ADDR;
                            else begin
                                n_ip = CW'(r_o1); n_cnt = r_cnt - CNT_W'(1);
                            end
                        end else begin
                            n_ip = ip2; n_cnt = r_cnt - CNT_W'(1);
                        end
                        n_st = S_DONE;
                    end
                    I_CALL: begin
                        s_we = 1'b1; s_addr = SW'(r_cnt); s_wd = r_o1;
                        n_st = S_PUSH2;
                    end
                    default: begin
                        alu_op = (r_w == I_ADD) ? A_ADD : (r_w == I_SUB) ? A_SUB :
                                 (r_w == I_MUL) ? A_MUL : (r_w == I_LT) ? A_LT : A_EQ;
                        s_we = 1'b1; s_addr = SW'(r_cnt - CNT_W'(2)); s_wd = alu_r;
                        n_cnt = r_cnt - CNT_W'(1); n_ip = ip1; n_a = '0;
                        n_st = S_DONE;
                    end
                endcase
            end
            S_PUSH2: begin
                s_we = 1'b1; s_addr = SW'(r_cnt + CNT_W'(1)); s_wd = 32'(ip3);
                n_st = S_PUSH3;
            end
            S_PUSH3: begin
                s_we = 1'b1; s_addr = SW'(r_cnt + CNT_W'(2)); s_wd = 32'(r_fp);
                n_fp = r_cnt + CNT_W'(2); n_cnt = r_cnt + CNT_W'(3);
                n_ip = CW'(r_o2); n_st = S_DONE;
            end
            // Return: read saved fp, return address, arg count, then value
            S_RF0: begin s_addr = SW'(r_fp); n_st = S_RF0W; end
            S_RF0W: begin n_s0 = s_rd; s_addr = SW'(r_fp - CNT_W'(1)); n_st = S_RF1W; end
            S_RF1W: begin n_s1 = s_rd; s_addr = SW'(r_fp - CNT_W'(2)); n_st = S_RF2W; end
            S_RF2W: begin n_a = s_rd; s_addr = SW'(r_cnt - CNT_W'(1)); n_st = S_RCHK; end
            S_RCHK: begin
                n_b = s_rd;
                ret_pc = CW'(r_s1);
                alu_op = A_SUB; alu_a = 32'(r_fp) - 32'd2; alu_b = r_a;
                if (r_a[31] || $signed(r_a) > $signed(32'(r_fp) - 32'd2) ||
                    r_s0[31] || r_s0 >= 32'(STACK_DEPTH)) begin
                    n_flt = F_UNDER; n_st = S_DONE;
                end else if (!in_code(r_s1)) begin
                    n_flt = F_ADDR; n_st = S_DONE;
                end else begin
                    s_we = 1'b1; s_addr = SW'(alu_r); s_wd = s_rd;
                    n_cnt = CNT_W'(alu_r) + CNT_W'(1);
                    n_fp = CNT_W'(r_s0); n_ip = ret_pc; n_st = S_DONE;
                end
            end
            S_DONE: begin
                if (r_in.opcode == OP_WRITE &&
                    32'(r_in.code_address) < 32'(CODE_DEPTH)) begin
                    c_we = 1'b1; c_addr = CW'(r_in.code_address);
                end
                if (r_flt != F_OK) n_halt = 1'b1;
                n_st = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_out.printed     = r_pr && (r_flt == F_OK);
                    n_out.print_value = (r_pr && (r_flt == F_OK)) ? r_a : '0;
                    n_out.halted      = r_halt;
                    n_out.fault       = r_flt;
                    n_out.next_pc     = 8'(r_ip);
                    n_ov = 1'b1; n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ip <= '0; r_cnt <= '0; r_fp <= '0;
            r_halt <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_ip <= n_ip; r_cnt <= n_cnt; r_fp <= n_fp;
            r_halt <= n_halt; r_ov <= n_ov;
        end
        r_in <= n_in; r_w <= n_w; r_o1 <= n_o1; r_o2 <= n_o2; r_a <= n_a;
        r_b <= n_b; r_s0 <= n_s0; r_s1 <= n_s1; r_flt <= n_flt; r_pr <= n_pr;
        r_out <= n_out;
    end
endmodule
`default_nettype wire

@@ sv/sbc_checker.sv @@
// Port checker for the stack bytecode core, bound to the top level.
`default_nettype none
module sbc_checker
    import sbc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_stall,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_word o_data
);
    // Hold a stalled result word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result word changed under stall");

    // A fault always halts
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.fault != F_OK |-> o_data.halted)
        else $error("fault without halt");

    // Print never coincides with a fault
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.printed |-> o_data.fault == F_OK)
        else $error("print with fault");

    // Accepted word makes the block busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("ready right after accept");
endmodule

bind stack_bytecode_cpu_unit sbc_checker u_sbc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data));
`default_nettype wire
